### sv/linked_list_insert_delete_top_defines.svh
// ----------------------------------------------------------------------------
// linked_list_insert_delete_top_defines.svh
// Assertion macros for the linked list block. Each macro uses the clk and
// rst names of the module that expands it.
// ----------------------------------------------------------------------------
`ifndef LINKED_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define LINKED_LIST_INSERT_DELETE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll_pkg
// Shared constants and types of the linked list block.
// ----------------------------------------------------------------------------
package ll_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 3;
  // count register holds 0..CAPACITY
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISPLAY   = 2'd3;

  // response status codes
  localparam logic [STAT_W-1:0] STAT_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ELEMENT  = 3'd4;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,      // keep contents
    OP_SHIFT_IN,  // insert at head: everything moves one cell toward the tail
    OP_APPEND,    // first empty cell takes the new value
    OP_ROT_KEEP,  // rotate: head value wraps to the tail
    OP_ROT_DROP   // rotate: head value is dropped
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [DATA_W-1:0]   data;
  } cell_cmd_t;

endpackage

### sv/ll_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll_req_if
// Request channel: valid/ready with kind and value.
// ----------------------------------------------------------------------------
interface ll_req_if;
  logic                              valid;
  logic                              ready;
  logic [ll_pkg::KIND_W-1:0]         kind;
  logic signed [ll_pkg::DATA_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

### sv/ll_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll_rsp_if
// Response channel: valid/ready with status, element and last.
// ----------------------------------------------------------------------------
interface ll_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ll_pkg::STAT_W-1:0]         status;
  logic signed [ll_pkg::DATA_W-1:0]  element;
  logic                              last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface

### sv/ll_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll_cell
// One list position: a value and an occupied flag, updated from neighbors.
// ----------------------------------------------------------------------------
module ll_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  ll_pkg::cell_cmd_t                 cmd,
  input  logic signed [ll_pkg::DATA_W-1:0]  left_val,
  input  logic                              left_occ,
  input  logic signed [ll_pkg::DATA_W-1:0]  right_val,
  input  logic                              right_occ,
  input  logic signed [ll_pkg::DATA_W-1:0]  head_val,
  output logic signed [ll_pkg::DATA_W-1:0]  val,
  output logic                              occ
);

  logic signed [ll_pkg::DATA_W-1:0] val_next;
  logic                             occ_next;

  always_comb begin
    val_next = val;
    occ_next = occ;
    case (cmd.op)
      ll_pkg::OP_SHIFT_IN: begin
        val_next = left_val;
        occ_next = left_occ;
      end
      ll_pkg::OP_APPEND: begin
        if (!occ && left_occ) begin
          val_next = cmd.data;
          occ_next = 1'b1;
        end
      end
      ll_pkg::OP_ROT_KEEP: begin
        // tail cell takes the old head
        if (occ) begin
          val_next = right_occ ? right_val : head_val;
        end
      end
      ll_pkg::OP_ROT_DROP: begin
        if (occ) begin
          if (right_occ) begin
            val_next = right_val;
          end else begin
            occ_next = 1'b0;
          end
        end
      end
      default: begin
        val_next = val;
        occ_next = occ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

### sv/ll_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ll_chain
// Row of list cells ordered head to tail, linked to their neighbors.
// ----------------------------------------------------------------------------
module ll_chain (
  input  logic                              clk,
  input  logic                              rst,
  input  ll_pkg::cell_cmd_t                 cmd,
  output logic signed [ll_pkg::DATA_W-1:0]  head_val,
  output logic [ll_pkg::CAPACITY-1:0]       occ
);

  logic signed [ll_pkg::DATA_W-1:0] vals [ll_pkg::CAPACITY];
  logic signed [ll_pkg::DATA_W-1:0] lv   [ll_pkg::CAPACITY];
  logic signed [ll_pkg::DATA_W-1:0] rv   [ll_pkg::CAPACITY];
  logic [ll_pkg::CAPACITY-1:0]      lo;
  logic [ll_pkg::CAPACITY-1:0]      ro;

  assign head_val = vals[0];

  for (genvar i = 0; i < ll_pkg::CAPACITY; i++) begin : g_cell
    // head cell sees the incoming value as an occupied left neighbor
    if (i == 0) begin : g_first
      assign lv[i] = cmd.data;
      assign lo[i] = 1'b1;
    end else begin : g_mid_l
      assign lv[i] = vals[i-1];
      assign lo[i] = occ[i-1];
    end
    if (i == ll_pkg::CAPACITY - 1) begin : g_last
      assign rv[i] = '0;
      assign ro[i] = 1'b0;
    end else begin : g_mid_r
      assign rv[i] = vals[i+1];
      assign ro[i] = occ[i+1];
    end

    ll_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_val  (lv[i]),
      .left_occ  (lo[i]),
      .right_val (rv[i]),
      .right_occ (ro[i]),
      .head_val  (vals[0]),
      .val       (vals[i]),
      .occ       (occ[i])
    );
  end

endmodule

### sv/linked_list_insert_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_insert_delete_top
// Bounded doubly linked list of signed 32-bit values with insert at front,
// insert at back, delete first match and display, over a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of 32 cells kept in list order, head in cell 0, so
// the head/tail pointers and links of a linked list are implied by position.
// An insert (front shifts every cell toward the tail, back fills the first
// free cell) answers with a single beat; a full list answers "list full"
// and is left untouched. Delete and display rotate the chain one cell per
// cycle while rsp is not stalled, for N steps, N being the list's entries:
// delete compares the head cell against the key on each step and drops the
// first match instead of wrapping it to the tail, so after N steps the list
// is back in order minus that node, and one status beat follows. Display
// emits the head value on each step, one beat per cycle, last set on the
// Nth. Inserts and requests on an empty list are answered from the accept
// alone; delete and display take the accept plus one rotation step per
// entry, N <= 32. Rsp backpressure pauses the rotation. A new request is
// taken in the idle state once the result register is free or being drained.
// ----------------------------------------------------------------------------
`include "linked_list_insert_delete_top_defines.svh"

module linked_list_insert_delete_top (
  input  logic         clk,
  input  logic         rst,
  ll_req_if.sink       req,
  ll_rsp_if.source     rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t                             state;
  logic [ll_pkg::CNT_W-1:0]           count;     // entries in the list
  logic [ll_pkg::CNT_W-1:0]           walk_pos;  // rotation steps done
  logic signed [ll_pkg::DATA_W-1:0]   key;
  logic                               mode_del;  // walk is a delete, else display
  logic                               found;     // delete already dropped a node

  // output register
  logic                               out_valid;
  logic [ll_pkg::STAT_W-1:0]          out_status;
  logic signed [ll_pkg::DATA_W-1:0]   out_element;
  logic                               out_last;

  ll_pkg::cell_cmd_t                  cmd;
  logic signed [ll_pkg::DATA_W-1:0]   head_val;
  logic [ll_pkg::CAPACITY-1:0]        occ;

  logic out_free;
  logic accept;
  logic step;
  logic drop;
  logic final_step;
  logic is_full;
  logic is_empty;
  logic is_insert;
  logic out_load;   // a new beat enters the output register

  ll_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .head_val (head_val),
    .occ      (occ)
  );

  always_comb begin
    out_free   = !out_valid || rsp.ready;
    req.ready  = (state == S_IDLE) && out_free;
    accept     = req.valid && req.ready;
    step       = (state == S_WALK) && out_free;
    drop       = mode_del && !found && (head_val == key);
    final_step = (walk_pos + ll_pkg::CNT_W'(1)) == count;
    is_full    = (count == ll_pkg::CAP_CNT);
    is_empty   = (count == '0);
    is_insert  = (req.kind == ll_pkg::KIND_INS_FRONT) ||
                 (req.kind == ll_pkg::KIND_INS_BACK);
    out_load   = (accept && (is_insert || is_empty)) ||
                 (step && (!mode_del || final_step));

    cmd.op   = ll_pkg::OP_HOLD;
    cmd.data = req.value;
    if (accept && !is_full) begin
      if (req.kind == ll_pkg::KIND_INS_FRONT) begin
        cmd.op = ll_pkg::OP_SHIFT_IN;
      end else if (req.kind == ll_pkg::KIND_INS_BACK) begin
        cmd.op = ll_pkg::OP_APPEND;
      end
    end
    if (step) begin
      cmd.op = drop ? ll_pkg::OP_ROT_DROP : ll_pkg::OP_ROT_KEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      walk_pos    <= '0;
      key         <= '0;
      mode_del    <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
      out_status  <= ll_pkg::STAT_DONE;
      out_element <= '0;
      out_last    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            out_element <= '0;
            out_last    <= 1'b1;
            if (is_insert) begin
              out_status <= is_full ? ll_pkg::STAT_FULL : ll_pkg::STAT_DONE;
              if (!is_full) begin
                count <= count + ll_pkg::CNT_W'(1);
              end
            end else if (is_empty) begin
              out_status <= ll_pkg::STAT_EMPTY;
            end else begin
              state    <= S_WALK;
              walk_pos <= '0;
              key      <= req.value;
              mode_del <= (req.kind == ll_pkg::KIND_DELETE);
              found    <= 1'b0;
            end
          end
        end
        S_WALK: begin
          if (step) begin
            walk_pos <= walk_pos + ll_pkg::CNT_W'(1);
            if (drop) begin
              found <= 1'b1;
            end
            if (mode_del) begin
              if (final_step) begin
                out_element <= '0;
                out_last    <= 1'b1;
                out_status  <= (found || drop) ? ll_pkg::STAT_DONE
                                               : ll_pkg::STAT_NOTFOUND;
                if (found || drop) begin
                  count <= count - ll_pkg::CNT_W'(1);
                end
                state <= S_IDLE;
              end
            end else begin
              out_status  <= ll_pkg::STAT_ELEMENT;
              out_element <= head_val;
              out_last    <= final_step;
              if (final_step) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.element = out_element;
  assign rsp.last    = out_last;

  // between requests the occupied cells always form the count
  `LL_ASSERT_NOW(a_occ_count, state == S_IDLE, $countones(occ) == int'(count), "occupied cells disagree with count")
  // a walk never runs on an empty list
  `LL_ASSERT_NOW(a_walk_nonempty, state == S_WALK, count != '0, "walk with empty list")
  // an insert that fits grows the list by one
  `LL_ASSERT_NEXT(a_insert_grow, accept && !is_full && is_insert,
    count == $past(count) + ll_pkg::CNT_W'(1), "insert did not grow list")

endmodule
